FILE: src/lzss_ring_buffer_decompressor_macros.svh
// assertion macros for the lzss ring buffer decompressor
// used by the top level; expects signals clk and rst in scope
`ifndef LZSS_RING_BUFFER_DECOMPRESSOR_MACROS_SVH
`define LZSS_RING_BUFFER_DECOMPRESSOR_MACROS_SVH

`ifndef SYNTHESIS
// property that holds in every cycle out of reset
`define LRBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lzrbd check failed");
// condition in one cycle implies a condition in the next
`define LRBD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lzrbd sequencing check failed");
`else
`define LRBD_ASSERT(lbl, prop)
`define LRBD_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: src/lzrbd_pkg.sv
// shared constants and types for the lzss ring buffer decompressor
// no dependencies
package lzrbd_pkg;

  // window geometry and reset values
  localparam int WINDOW_SIZE_DEF = 4096;
  localparam int BYTE_W          = 8;
  localparam int CFG_W           = 12;
  localparam int LEN_W           = 5;
  localparam int LEN_BIAS        = 3;
  localparam logic [7:0]  FILL_RESET  = 8'h20;
  localparam logic [11:0] START_RESET = 12'hFEE;

  // configuration register indexes
  localparam logic CFG_FILL  = 1'b0;
  localparam logic CFG_START = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LIT   = 4'b0010,
    S_READ  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

endpackage

FILE: src/lzrbd_ram.sv
// generic single write port ram with registered read
// depends on lzrbd_pkg for default sizes
module lzrbd_ram #(
  parameter int WIDTH = lzrbd_pkg::BYTE_W,
  parameter int DEPTH = lzrbd_pkg::WINDOW_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/lzss_ring_buffer_decompressor.sv
// lzss decompressor with a ring window, one byte per word on both sides
// depends on lzrbd_pkg, lzrbd_ram and lzss_ring_buffer_decompressor_macros.svh
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata = in_byte, s_tuser = file_start
//  m_*       out  m_tvalid/m_tready  m_tdata = out_byte, m_tlast = run_last
//  cfg_*     in   cfg_we             cfg_index, cfg_data
//
// flag byte and reference first byte are taken in idle; a literal passes S_LIT;
// a reference second byte runs S_READ then S_WRITE through the window ram
// (one read and one write back per copied byte).
// the window is never cleared: a fill count since file start marks which
// entries hold written data, others read as the fill value; no init sweep.
// input is taken only when the sequencer is idle; a stalled output holds it.
`include "lzss_ring_buffer_decompressor_macros.svh"

module lzss_ring_buffer_decompressor #(
  parameter int WINDOW_SIZE = lzrbd_pkg::WINDOW_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] file_start
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int PosW = $clog2(WINDOW_SIZE);
  localparam int LenW = lzrbd_pkg::LEN_W;

  lzrbd_pkg::state_t state;

  logic [7:0]      fill_cfg;
  logic [PosW-1:0] start_cfg;
  logic [7:0]      act_fill;
  logic [PosW-1:0] act_start;
  logic [PosW-1:0] wpos;
  logic [PosW-1:0] wcount;
  logic            wfull;
  logic [7:0]      flag_bits;
  logic [3:0]      flag_index;
  logic            expect_hi;
  logic [7:0]      held;
  logic [PosW-1:0] src;
  logic [LenW-1:0] rem;

  logic            in_acc;
  logic            out_free;
  logic [PosW-1:0] src_offset;
  logic            rd_hit;
  logic [7:0]      ram_rdata;
  logic [7:0]      win_byte;
  logic            ram_we;
  logic [7:0]      ram_wdata;
  logic            ram_re;

  // handshake
  assign s_tready = (state == lzrbd_pkg::S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // entry holds written data if it lies in the range filled since file start
  assign src_offset = src - act_start;
  assign rd_hit     = wfull || (src_offset < wcount);
  assign win_byte   = rd_hit ? ram_rdata : act_fill;

  // window ram ports
  assign ram_re    = (state == lzrbd_pkg::S_READ);
  assign ram_we    = out_free &&
                     ((state == lzrbd_pkg::S_LIT) || (state == lzrbd_pkg::S_WRITE));
  assign ram_wdata = (state == lzrbd_pkg::S_LIT) ? held : win_byte;

  lzrbd_ram #(
    .WIDTH (lzrbd_pkg::BYTE_W),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (src),
    .rdata (ram_rdata)
  );

  // sequencer, window bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lzrbd_pkg::S_IDLE;
      fill_cfg   <= lzrbd_pkg::FILL_RESET;
      start_cfg  <= PosW'(lzrbd_pkg::START_RESET);
      act_fill   <= lzrbd_pkg::FILL_RESET;
      act_start  <= PosW'(lzrbd_pkg::START_RESET);
      wpos       <= PosW'(lzrbd_pkg::START_RESET);
      wcount     <= '0;
      wfull      <= 1'b0;
      flag_bits  <= '0;
      flag_index <= 4'd8;
      expect_hi  <= 1'b0;
      held       <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // register writes, used from the next file start on
      if (cfg_we) begin
        case (cfg_index)
          lzrbd_pkg::CFG_FILL:  fill_cfg  <= cfg_data[7:0];
          lzrbd_pkg::CFG_START: start_cfg <= PosW'(cfg_data);
          default: ;
        endcase
      end

      // output word taken and no new word loaded this cycle
      if (m_tvalid && m_tready && !ram_we) begin
        m_tvalid <= 1'b0;
      end

      // advance write position and fill count on each window write
      if (ram_we) begin
        wpos <= wpos + 1'b1;
        if (!wfull) begin
          wcount <= wcount + 1'b1;
          if (wcount == '1) begin
            wfull <= 1'b1;
          end
        end
      end

      case (state)
        lzrbd_pkg::S_IDLE: begin
          if (in_acc) begin
            if (s_tuser) begin
              // new file: window logically refilled, byte is the flag byte
              act_fill   <= fill_cfg;
              act_start  <= start_cfg;
              wpos       <= start_cfg;
              wcount     <= '0;
              wfull      <= 1'b0;
              expect_hi  <= 1'b0;
              held       <= '0;
              flag_bits  <= s_tdata;
              flag_index <= '0;
            end else if (expect_hi) begin
              // second reference byte: start the copy
              src        <= PosW'({s_tdata[3:0], held});
              rem        <= LenW'(s_tdata[7:4]) + LenW'(lzrbd_pkg::LEN_BIAS - 1);
              expect_hi  <= 1'b0;
              flag_index <= flag_index + 1'b1;
              state      <= lzrbd_pkg::S_READ;
            end else if (flag_index[3]) begin
              flag_bits  <= s_tdata;
              flag_index <= '0;
            end else if (flag_bits[flag_index[2:0]]) begin
              held       <= s_tdata;
              flag_index <= flag_index + 1'b1;
              state      <= lzrbd_pkg::S_LIT;
            end else begin
              held      <= s_tdata;
              expect_hi <= 1'b1;
            end
          end
        end

        lzrbd_pkg::S_LIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= held;
            m_tlast  <= 1'b1;
            state    <= lzrbd_pkg::S_IDLE;
          end
        end

        lzrbd_pkg::S_READ: begin
          state <= lzrbd_pkg::S_WRITE;
        end

        lzrbd_pkg::S_WRITE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= win_byte;
            m_tlast  <= (rem == '0);
            src      <= src + 1'b1;
            rem      <= rem - 1'b1;
            state    <= (rem == '0) ? lzrbd_pkg::S_IDLE : lzrbd_pkg::S_READ;
          end
        end

        default: begin
          state <= lzrbd_pkg::S_IDLE;
        end
      endcase
    end
  end

  // a file start leaves an empty window and waits for items
  `LRBD_ASSERT_NEXT(a_file_start, in_acc && s_tuser, (wcount == '0) && !wfull && (flag_index == '0))
  // every read is followed by its write back
  `LRBD_ASSERT_NEXT(a_read_write, state == lzrbd_pkg::S_READ, state == lzrbd_pkg::S_WRITE)
  // copied byte is marked last exactly when the count runs out
  `LRBD_ASSERT_NEXT(a_copy_last, (state == lzrbd_pkg::S_WRITE) && out_free, m_tvalid && (m_tlast == $past(rem == '0)))

endmodule

FILE: tb/testbench.sv
// self-checking testbench for lzss_ring_buffer_decompressor: a mirror of the 4k
// window decodes every accepted word and checks each output word in order
// depends on lzrbd_pkg and the decompressor rtl
`timescale 1ns / 1ps

module testbench;

  localparam int WIN_DEPTH   = lzrbd_pkg::WINDOW_SIZE_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 50;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_byte
  logic        s_tuser;   // [0] file_start
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] out_byte
  logic        m_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [11:0] cfg_data;

  lzss_ring_buffer_decompressor i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // window mirror and decoder state
  logic [7:0]  window_mirror [WIN_DEPTH];
  logic [11:0] wpos;
  logic [7:0]  flag_byte;
  int          flag_pos;
  bit          want_high_half;
  logic [7:0]  low_half;
  logic [7:0]  fill_cfg;
  logic [11:0] start_cfg;

  out_word_t pending_bytes[$];

  int error_count;
  int words_sent;
  int bytes_checked;
  int files_started;
  int reg_writes;
  int cycle_count;
  int src_gap_pct;
  int snk_idle_pct;
  int hold_cycles;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, pending_bytes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    if (error_count < MAX_PRINTS)
      $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    error_count++;
  endtask

  // refill the window and restart the flag sequence
  function automatic void start_file();
    for (int i = 0; i < WIN_DEPTH; i++) window_mirror[i] = fill_cfg;
    wpos           = start_cfg;
    flag_byte      = 8'h00;
    flag_pos       = 8;
    want_high_half = 1'b0;
    low_half       = 8'h00;
  endfunction

  // decode one accepted word into the bytes it must produce
  function automatic void decode_byte(input logic [7:0] b, input logic fs);
    int          len;
    logic [11:0] src;
    logic [7:0]  v;
    out_word_t   w;
    if (fs) begin
      start_file();
      files_started++;
    end
    if (want_high_half) begin
      len = int'(b[7:4]) + lzrbd_pkg::LEN_BIAS;
      src = {b[3:0], low_half};
      for (int k = 0; k < len; k++) begin
        v = window_mirror[src];
        src = src + 12'd1;
        window_mirror[wpos] = v;
        wpos = wpos + 12'd1;
        w.data = v;
        w.last = (k == len - 1);
        pending_bytes.push_back(w);
      end
      want_high_half = 1'b0;
      flag_pos++;
    end else if (flag_pos >= 8) begin
      flag_byte = b;
      flag_pos  = 0;
    end else if (flag_byte[flag_pos]) begin
      window_mirror[wpos] = b;
      wpos = wpos + 12'd1;
      w.data = b;
      w.last = 1'b1;
      pending_bytes.push_back(w);
      flag_pos++;
    end else begin
      low_half       = b;
      want_high_half = 1'b1;
    end
  endfunction

  // output checker
  always @(posedge clk) begin : out_check
    out_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected output word, data", 0, int'(m_tdata));
      end else begin
        want = pending_bytes.pop_front();
        if (m_tdata !== want.data)
          report_mismatch("out_byte", int'(want.data), int'(m_tdata));
        if (m_tlast !== want.last)
          report_mismatch("run_last", int'(want.last), int'(m_tlast));
      end
    end
  end

  // receiver: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // send one word; called and returns at a falling edge
  task automatic send_word(input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= fs;
    do @(posedge clk); while (!s_tready);
    decode_byte(b, fs);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_ref(input logic [11:0] pos, input int len);
    logic [3:0] len_code;
    len_code = 4'(len - lzrbd_pkg::LEN_BIAS);
    send_word(pos[7:0], 1'b0);
    send_word({len_code, pos[11:8]}, 1'b0);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == lzrbd_pkg::CFG_FILL) fill_cfg = val[7:0];
    else start_cfg = val;
    reg_writes++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // mostly recent history so copies repeat fresh data, sometimes anywhere
  function automatic logic [11:0] pick_source();
    if ($urandom_range(2) == 0) return 12'($urandom_range(WIN_DEPTH - 1));
    return wpos - 12'($urandom_range(1, 30));
  endfunction

  // well-formed file with random content, optionally cut short
  task automatic send_file(input int groups, input bit allow_cut);
    logic [7:0] flags;
    int         stop_at;
    stop_at = groups * 8;
    if (allow_cut && $urandom_range(3) == 0) stop_at = $urandom_range(groups * 8 - 1);
    for (int g = 0; g < groups; g++) begin
      flags = 8'($urandom_range(255));
      send_word(flags, g == 0);
      for (int i = 0; i < 8; i++) begin
        if (g * 8 + i == stop_at) begin
          // short group, sometimes with a dangling reference half
          if (!flags[i] && $urandom_range(1)) send_word(8'($urandom_range(255)), 1'b0);
          return;
        end
        if (flags[i]) send_word(8'($urandom_range(255)), 1'b0);
        else send_ref(pick_source(), $urandom_range(3, 18));
      end
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++)
      send_word(8'($urandom_range(255)), $urandom_range(9) == 0);
  endtask

  // extremes, overlap, wrap, cut-off reference and short group
  task automatic test_directed();
    send_word(8'b0000_0011, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_ref(lzrbd_pkg::START_RESET, 5);
    send_word(8'h00, 1'b1);
    send_ref(12'h000, 3);
    send_ref(12'hFFF, 18);
    send_word(8'h5A, 1'b0);
    send_word(8'h01, 1'b1);
    send_word(8'hA5, 1'b0);
    send_ref(lzrbd_pkg::START_RESET, 18);
    send_ref(lzrbd_pkg::START_RESET + 12'd1, 10);
    send_word(8'hFF, 1'b1);
    send_word(8'h80, 1'b0);
    wait_drained();
  endtask

  // both registers at their extremes
  task automatic test_config_extremes();
    write_reg(lzrbd_pkg::CFG_FILL, 12'h000);
    write_reg(lzrbd_pkg::CFG_START, 12'h000);
    send_word(8'h00, 1'b1);
    send_ref(12'hFFF, 3);
    send_ref(12'h000, 18);
    wait_drained();
    write_reg(lzrbd_pkg::CFG_FILL, 12'hFFF);
    write_reg(lzrbd_pkg::CFG_START, 12'hFFF);
    send_word(8'h0F, 1'b1);
    for (int i = 0; i < 4; i++) send_word(8'($urandom_range(255)), 1'b0);
    send_ref(12'hFFF, 4);
    send_ref(12'h010, 18);
    send_ref(12'h001, 7);
    send_ref(12'h800, 12);
    wait_drained();
  endtask

  // long receiver hold-off while words keep coming
  task automatic test_backpressure();
    hold_cycles = 300;
    send_word(8'hFF, 1'b1);
    for (int i = 0; i < 8; i++) send_word(8'($urandom_range(255)), 1'b0);
    send_word(8'h00, 1'b0);
    for (int i = 0; i < 4; i++) send_ref(wpos - 12'd2, 18);
    wait_drained();
  endtask

  task automatic test_random_phase(input int src_pct, input int snk_pct, input int n);
    int target;
    src_gap_pct  = src_pct;
    snk_idle_pct = snk_pct;
    write_reg(lzrbd_pkg::CFG_FILL, 12'($urandom_range(4095)));
    write_reg(lzrbd_pkg::CFG_START, 12'($urandom_range(4095)));
    target = words_sent + n;
    while (words_sent < target) begin
      if ($urandom_range(99) < 85) send_file($urandom_range(1, 2), 1'b1);
      else send_noise($urandom_range(1, 6));
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tuser      = 1'b0;
    m_tready     = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = lzrbd_pkg::CFG_FILL;
    cfg_data     = 12'h000;
    hold_cycles  = 0;
    src_gap_pct  = 18;
    snk_idle_pct = 80;
    fill_cfg     = lzrbd_pkg::FILL_RESET;
    start_cfg    = lzrbd_pkg::START_RESET;
    start_file();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_phase(18, 80, 35);
    test_random_phase(80, 18, 35);
    test_random_phase(0, 0, 35);

    $display("covered %0d input words over %0d file starts, %0d register writes",
             words_sent, files_started, reg_writes);
    $display("checked %0d output words in %0d cycles", bytes_checked, cycle_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
